// ===== rtl/hashed_block_buffer_cache_tags_core_assert.svh =====
// Assertion macros for the buffer cache tag manager
`ifndef HASHED_BLOCK_BUFFER_CACHE_TAGS_CORE_ASSERT_SVH
`define HASHED_BLOCK_BUFFER_CACHE_TAGS_CORE_ASSERT_SVH
// Check that a condition implies a consequence in the next cycle
`define HBC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence in the same cycle
`define HBC_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);
`endif

// ===== rtl/hbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared codes and types for the buffer cache tag manager.
// ----------------------------------------------------------------------------
package hbc_pkg;
  localparam logic [1:0] ACT_GET   = 2'd0;
  localparam logic [1:0] ACT_PIN   = 2'd1;
  localparam logic [1:0] ACT_UNPIN = 2'd2;
  localparam int unsigned REF_W = 16;
  localparam logic [REF_W-1:0] REF_MAX = '1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_FREE = 1'b1;
endpackage

// ===== rtl/hbc_hash.sv =====
// ----------------------------------------------------------------------------
// hbc_hash
// Sequential (dev + blockno) mod NUM_BUCKETS: fold the upper bytes back onto
// the low byte, one fold per cycle, then read the low byte through a table.
// ----------------------------------------------------------------------------
module hbc_hash #(
  parameter int unsigned NUM_BUCKETS = 17,
  parameter int unsigned BK_W = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  logic [31:0]     sum,
  output logic            done,
  output logic [BK_W-1:0] bucket
);
  // weight of 2^8 modulo the bucket count
  localparam logic [7:0] FOLD_W = 8'(256 % NUM_BUCKETS);

  function automatic logic [256*BK_W-1:0] build_tab();
    logic [256*BK_W-1:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) t[i*BK_W +: BK_W] = BK_W'(i % NUM_BUCKETS);
    return t;
  endfunction

  localparam logic [256*BK_W-1:0] MOD_TAB = build_tab();

  logic [31:0] val_r, val_nxt;
  logic        run_r, run_nxt;
  logic        fits_byte;

  assign fits_byte = val_r[31:8] == 24'd0;

  always_comb begin
    val_nxt = val_r; run_nxt = run_r;
    if (go) begin
      val_nxt = sum; run_nxt = 1'b1;
    end else if (run_r) begin
      // fold the upper bytes onto the low byte until the value fits a byte
      if (!fits_byte)
        val_nxt = {8'd0, val_r[31:8]} * {24'd0, FOLD_W} + {24'd0, val_r[7:0]};
      else
        run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    val_r <= val_nxt;
  end

  assign done = run_r && fits_byte;
  assign bucket = MOD_TAB[BK_W*val_r[7:0] +: BK_W];
endmodule

// ===== rtl/hashed_block_buffer_cache_tags_core.sv =====
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_tags_core
// Tag manager for a hashed block buffer cache.
// ----------------------------------------------------------------------------
// Pin, unpin and the unused action pass through the S_PIN state after the
// accept edge; the result word shows on the next cycle, when busy is already
// low. A get first folds dev + blockno down to a byte and reads its bucket from
// a table, then walks its bucket one buffer per cycle. A miss walks its own
// bucket again and then the other buckets in index order, one buffer per cycle
// within a bucket and through S_BKT between buckets, and relinks the buffer it
// takes in S_UNL and then S_APP. busy is high throughout; the result word shows
// on the out_ ports for one cycle with out_valid, and the receiver cannot stall it.
module hashed_block_buffer_cache_tags_core #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned NUM_BUCKETS = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_dev,
  input  logic [31:0] in_blockno,
  input  logic [4:0]  in_buffer_index,
  output logic        out_valid,
  output logic [4:0]  out_result_index,
  output logic        out_was_valid,
  output logic        out_status
);
  import hbc_pkg::*;
  `include "hashed_block_buffer_cache_tags_core_assert.svh"

  localparam int unsigned LW = $clog2(NUM_BUFFERS + 1);
  localparam int unsigned IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned BKW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [LW-1:0] NIL = LW'(NUM_BUFFERS);
  localparam logic [BKW:0] NBK = NUM_BUCKETS[BKW:0];

  localparam logic [3:0] S_IDLE = 4'd0, S_HASH = 4'd1, S_SRCH = 4'd2,
                         S_FREE = 4'd3, S_UNL = 4'd4, S_APP = 4'd5,
                         S_DONE = 4'd6, S_PIN = 4'd7, S_BKT = 4'd8;

  logic [31:0]      tdev_r [NUM_BUFFERS];
  logic [31:0]      tblk_r [NUM_BUFFERS];
  logic [REF_W-1:0] refc_r [NUM_BUFFERS];
  logic             cval_r [NUM_BUFFERS];
  logic [LW-1:0]    nxt_r  [NUM_BUFFERS];
  logic [LW-1:0]    prv_r  [NUM_BUFFERS];
  logic [LW-1:0]    head_r [NUM_BUCKETS];
  logic [LW-1:0]    tail_r [NUM_BUCKETS];

  logic [3:0]     st_r;
  logic [1:0]     act_r;
  logic [31:0]    dev_r, blk_r;
  logic [4:0]     bidx_r;
  logic [BKW-1:0] bk_r, kb_r;
  logic [LW-1:0]  cur_r;
  logic [LW-1:0]  got_r;
  logic [LW-1:0]  steps_r;
  logic           other_r;
  logic           ov_r, owv_r, ost_r;
  logic [4:0]     oidx_r;

  logic           h_done;
  logic [BKW-1:0] h_bk;
  logic [IW-1:0]  ci, gi;
  logic [BKW:0]   bkt_nk;
  logic           bkt_end;

  hbc_hash #(.NUM_BUCKETS(NUM_BUCKETS), .BK_W(BKW)) u_hash (
    .clk(clk), .rst_n(rst_n), .go(start && !busy && in_action == ACT_GET),
    .sum(in_dev + in_blockno), .done(h_done), .bucket(h_bk));

  assign ci = cur_r[IW-1:0];
  assign gi = got_r[IW-1:0];
  assign busy = st_r != S_IDLE;

  // advance to the next other bucket in index order
  always_comb begin
    bkt_nk = other_r ? {1'b0, kb_r} + 1'b1 : '0;
    if (bkt_nk == {1'b0, bk_r}) bkt_nk = bkt_nk + 1'b1;
    bkt_end = bkt_nk >= NBK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= st_r == S_PIN || st_r == S_DONE || (st_r == S_BKT && bkt_end);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        head_r[i] <= (i < NUM_BUFFERS) ? LW'(i) : NIL;
        tail_r[i] <= (i < NUM_BUFFERS)
          ? LW'(i + ((NUM_BUFFERS - 1 - i) / NUM_BUCKETS) * NUM_BUCKETS) : NIL;
      end
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tdev_r[i] <= '1; tblk_r[i] <= '1; refc_r[i] <= '0; cval_r[i] <= 1'b0;
        nxt_r[i] <= (i + NUM_BUCKETS < NUM_BUFFERS) ? LW'(i + NUM_BUCKETS) : NIL;
        prv_r[i] <= (i >= NUM_BUCKETS) ? LW'(i - NUM_BUCKETS) : NIL;
      end
    end else begin
      case (st_r)
        S_IDLE: if (start) begin
          act_r <= in_action; dev_r <= in_dev; blk_r <= in_blockno;
          bidx_r <= in_buffer_index;
          st_r <= (in_action == ACT_GET) ? S_HASH : S_PIN;
        end
        S_PIN: begin
          if ((act_r == ACT_PIN || act_r == ACT_UNPIN) && {1'b0, bidx_r} <
              6'(NUM_BUFFERS)) begin
            if (act_r == ACT_PIN && refc_r[bidx_r[IW-1:0]] != REF_MAX)
              refc_r[bidx_r[IW-1:0]] <= refc_r[bidx_r[IW-1:0]] + 1'b1;
            if (act_r == ACT_UNPIN && refc_r[bidx_r[IW-1:0]] != '0)
              refc_r[bidx_r[IW-1:0]] <= refc_r[bidx_r[IW-1:0]] - 1'b1;
          end
          oidx_r <= (act_r == ACT_PIN || act_r == ACT_UNPIN) ? bidx_r : '0;
          owv_r <= 1'b0; ost_r <= STATUS_OK; st_r <= S_IDLE;
        end
        S_HASH: if (h_done) begin
          bk_r <= h_bk; cur_r <= head_r[h_bk]; steps_r <= '0; st_r <= S_SRCH;
        end
        S_SRCH: begin
          if (cur_r == NIL || steps_r == NIL) begin
            cur_r <= head_r[bk_r]; kb_r <= bk_r; other_r <= 1'b0;
            steps_r <= '0; st_r <= S_FREE;
          end else if (tdev_r[ci] == dev_r && tblk_r[ci] == blk_r) begin
            if (refc_r[ci] != REF_MAX) refc_r[ci] <= refc_r[ci] + 1'b1;
            got_r <= cur_r; st_r <= S_DONE;
          end else begin
            cur_r <= nxt_r[ci]; steps_r <= steps_r + 1'b1;
          end
        end
        S_FREE: begin
          if (cur_r == NIL || steps_r == NIL) st_r <= S_BKT;
          else if (refc_r[ci] == '0) begin
            got_r <= cur_r; st_r <= S_UNL;
          end else begin
            cur_r <= nxt_r[ci]; steps_r <= steps_r + 1'b1;
          end
        end
        S_BKT: begin
          if (bkt_end) begin
            oidx_r <= '0; owv_r <= 1'b0; ost_r <= STATUS_NO_FREE; st_r <= S_IDLE;
          end else begin
            kb_r <= bkt_nk[BKW-1:0]; other_r <= 1'b1;
            cur_r <= head_r[bkt_nk[BKW-1:0]];
            steps_r <= '0; st_r <= S_FREE;
          end
        end
        S_UNL: begin
          if (prv_r[gi] != NIL) nxt_r[prv_r[gi][IW-1:0]] <= nxt_r[gi];
          else head_r[kb_r] <= nxt_r[gi];
          if (nxt_r[gi] != NIL) prv_r[nxt_r[gi][IW-1:0]] <= prv_r[gi];
          else tail_r[kb_r] <= prv_r[gi];
          refc_r[gi] <= REF_W'(1); tdev_r[gi] <= dev_r; tblk_r[gi] <= blk_r;
          cval_r[gi] <= 1'b0; st_r <= S_APP;
        end
        S_APP: begin
          nxt_r[gi] <= NIL;
          if (tail_r[bk_r] == NIL) begin
            head_r[bk_r] <= got_r; prv_r[gi] <= NIL;
          end else begin
            nxt_r[tail_r[bk_r][IW-1:0]] <= got_r; prv_r[gi] <= tail_r[bk_r];
          end
          tail_r[bk_r] <= got_r; st_r <= S_DONE;
        end
        S_DONE: begin
          oidx_r <= 5'(got_r); owv_r <= cval_r[gi]; ost_r <= STATUS_OK;
          cval_r[gi] <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_result_index = oidx_r;
  assign out_was_valid = owv_r;
  assign out_status = ost_r;

  `HBC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept did not raise busy")
  `HBC_ASSERT_NOW(a_out_idle, clk, rst_n, out_valid, st_r == S_IDLE, "result while working")
  `HBC_ASSERT_NOW(a_err_fields, clk, rst_n, out_valid && out_status,
    out_result_index == 5'd0 && !out_was_valid, "error result fields nonzero")
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives gets, pins, unpins and the unused action into the buffer cache tag
// manager and checks every result word against a behavioral copy of the tag,
// refcount and bucket list state.
// ----------------------------------------------------------------------------
class cache_tag_scoreboard;
  localparam int NBUF = 32;
  localparam int NBKT = 17;
  localparam int NIL = NBUF;

  logic [31:0] tag_dev [NBUF];
  logic [31:0] tag_blk [NBUF];
  logic [15:0] refs [NBUF];
  bit          cvalid [NBUF];
  int          nxt [NBUF];
  int          prv [NBUF];
  int          head [NBKT];
  int          tail [NBKT];

  logic [6:0]  pending_words [$];
  int          errors;

  function void clear_state();
    for (int k = 0; k < NBKT; k++) begin
      head[k] = NIL;
      tail[k] = NIL;
    end
    for (int i = 0; i < NBUF; i++) begin
      tag_dev[i] = '1;
      tag_blk[i] = '1;
      refs[i] = '0;
      cvalid[i] = 1'b0;
      link_tail(i % NBKT, i);
    end
    errors = 0;
  endfunction

  function void link_tail(int bk, int b);
    nxt[b] = NIL;
    if (tail[bk] == NIL) begin
      head[bk] = b;
      prv[b] = NIL;
    end else begin
      nxt[tail[bk]] = b;
      prv[b] = tail[bk];
    end
    tail[bk] = b;
  endfunction

  function void drop_link(int bk, int b);
    int p, n;
    p = prv[b];
    n = nxt[b];
    if (p != NIL) nxt[p] = n;
    else head[bk] = n;
    if (n != NIL) prv[n] = p;
    else tail[bk] = p;
    nxt[b] = NIL;
    prv[b] = NIL;
  endfunction

  function int grab_free(int bk);
    int b;
    b = head[bk];
    for (int s = 0; s < NBUF && b != NIL; s++) begin
      if (refs[b] == 0) begin
        drop_link(bk, b);
        return b;
      end
      b = nxt[b];
    end
    return NIL;
  endfunction

  // Compute the result word {index, was_valid, status} and queue it.
  function void note_request(logic [1:0] act, logic [31:0] dev, logic [31:0] blk,
                             logic [4:0] idx);
    logic [31:0] sum;
    int bk, b, got;
    logic [4:0] ri;
    logic wv, st;
    ri = '0; wv = 1'b0; st = hbc_pkg::STATUS_OK;
    if (act == hbc_pkg::ACT_GET) begin
      sum = dev + blk;
      bk = sum % NBKT;
      got = NIL;
      b = head[bk];
      for (int s = 0; s < NBUF && b != NIL; s++) begin
        if (tag_dev[b] == dev && tag_blk[b] == blk) begin
          got = b;
          break;
        end
        b = nxt[b];
      end
      if (got != NIL) begin
        if (refs[got] != hbc_pkg::REF_MAX) refs[got]++;
      end else begin
        got = grab_free(bk);
        for (int k = 0; k < NBKT && got == NIL; k++)
          if (k != bk) got = grab_free(k);
        if (got != NIL) begin
          refs[got] = 16'd1;
          tag_dev[got] = dev;
          tag_blk[got] = blk;
          cvalid[got] = 1'b0;
          link_tail(bk, got);
        end
      end
      if (got == NIL) st = hbc_pkg::STATUS_NO_FREE;
      else begin
        ri = got[4:0];
        wv = cvalid[got];
        cvalid[got] = 1'b1;
      end
    end else if (act == hbc_pkg::ACT_PIN || act == hbc_pkg::ACT_UNPIN) begin
      ri = idx;
      if (act == hbc_pkg::ACT_PIN) begin
        if (refs[idx] != hbc_pkg::REF_MAX) refs[idx]++;
      end else if (refs[idx] != 0) refs[idx]--;
    end
    pending_words.push_back({ri, wv, st});
  endfunction

  function void check_word(logic [4:0] ri, logic wv, logic st);
    logic [6:0] w;
    if (pending_words.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    w = pending_words.pop_front();
    if (ri !== w[6:2]) begin
      $error("result_index expected %0d actual %0d", w[6:2], ri);
      errors++;
    end
    if (wv !== w[1]) begin
      $error("was_valid expected %0d actual %0d", w[1], wv);
      errors++;
    end
    if (st !== w[0]) begin
      $error("status expected %0d actual %0d", w[0], st);
      errors++;
    end
  endfunction
endclass

module tb;
  import hbc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_action = ACT_PIN;
  logic [31:0] in_dev = 0;
  logic [31:0] in_blockno = 0;
  logic [4:0]  in_buffer_index = 0;
  logic        out_valid;
  logic [4:0]  out_result_index;
  logic        out_was_valid;
  logic        out_status;

  cache_tag_scoreboard cache_model;
  logic [31:0] recent_dev [8];
  logic [31:0] recent_blk [8];

  hashed_block_buffer_cache_tags_core uut (.*);

  always #4 clk = ~clk;

  always @(posedge clk)
    if (rst_n && out_valid) cache_model.check_word(out_result_index, out_was_valid, out_status);

  // Present one word and hold it until accepted.
  task automatic issue(logic [1:0] act, logic [31:0] dev, logic [31:0] blk, logic [4:0] idx);
    start <= 1;
    in_action <= act;
    in_dev <= dev;
    in_blockno <= blk;
    in_buffer_index <= idx;
    do @(posedge clk); while (busy);
    cache_model.note_request(act, dev, blk, idx);
  endtask

  task automatic idle_cycles(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic random_word();
    int r, s;
    logic [31:0] d, b;
    r = $urandom_range(99);
    s = $urandom_range(7);
    if (r < 45) begin
      if ($urandom_range(1)) begin
        d = recent_dev[s];
        b = recent_blk[s];
      end else begin
        d = $urandom_range(1) ? $urandom : $urandom_range(5);
        b = $urandom_range(1) ? $urandom : $urandom_range(40);
        recent_dev[s] = d;
        recent_blk[s] = b;
      end
      issue(ACT_GET, d, b, 5'($urandom));
    end else if (r < 70) issue(ACT_PIN, $urandom, $urandom, 5'($urandom));
    else if (r < 97) issue(ACT_UNPIN, $urandom, $urandom, 5'($urandom));
    else issue(ACT_UNUSED, $urandom, $urandom, 5'($urandom));
  endtask

  initial begin
    int wait_cnt;
    cache_model = new();
    cache_model.clear_state();
    for (int i = 0; i < 8; i++) begin
      recent_dev[i] = i;
      recent_blk[i] = 3 * i;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, hits, wrap of the hash sum, unused action.
    issue(ACT_GET, '1, '1, 5'd0);
    issue(ACT_GET, '1, 32'd1, 5'd0);
    issue(ACT_GET, 32'd5, 32'd7, 5'd31);
    issue(ACT_GET, 32'd5, 32'd7, 5'd0);
    issue(ACT_GET, 0, 0, 5'd0);
    issue(ACT_PIN, '1, '1, 5'd31);
    issue(ACT_UNPIN, 0, 0, 5'd31);
    issue(ACT_UNPIN, 0, 0, 5'd31);
    issue(ACT_UNPIN, 0, 0, 5'd0);
    issue(ACT_UNUSED, '1, '1, 5'd31);
    // Pin every buffer so that a fresh get finds nothing free.
    for (int i = 0; i < 32; i++) issue(ACT_PIN, 0, 0, i[4:0]);
    issue(ACT_GET, 32'h1234, 32'h5678, 5'd0);
    for (int i = 0; i < 32; i++) issue(ACT_UNPIN, 0, 0, i[4:0]);
    idle_cycles(1);

    for (int n = 0; n < 375;) begin
      int burst;
      burst = $urandom_range(12, 1);
      for (int k = 0; k < burst; k++) begin
        random_word();
        n++;
      end
      if (n > 200 && n < 215) begin
        // hold off until every expected word has come
        start <= 0;
        while (cache_model.pending_words.size() != 0) @(posedge clk);
      end
      if ($urandom_range(3) != 0) idle_cycles($urandom_range(40, 1));
    end
    start <= 0;
    wait_cnt = 0;
    while (cache_model.pending_words.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (100) @(posedge clk);
    if (cache_model.errors == 0 && cache_model.pending_words.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hbc_pkg.sv
rtl/hbc_hash.sv
rtl/hashed_block_buffer_cache_tags_core.sv
test/tb.sv
